FILE: hdl/gdu_pkg.sv
// Shared widths, constants and the pipeline sideband type of the two-body
// gravity derivative unit. No dependencies.
`timescale 1ns / 1ps

package gdu_pkg;

    localparam int PosW     = 40;              // position field width
    localparam int VelW     = 32;              // velocity / rate width
    localparam int AccW     = 48;              // acceleration width
    localparam int MuW      = 40;              // gravitational parameter width
    localparam int MagW     = 40;              // magnitude of a position (holds 2^39)
    localparam int HalfW    = MagW / 2;        // chunk of a magnitude for squaring
    localparam int SqW      = 2 * HalfW;       // one partial product of a square
    localparam int R2W      = 80;              // x^2 + y^2 (max 2^79)
    localparam int RadPad   = 32;              // radicand is r2 shifted by 2^32
    localparam int SW       = 56;              // root width, one bit per step
    localparam int SqrSteps = SW;
    localparam int SqrRemW  = SW + 4;          // partial remainder of the root
    localparam int ChunkW   = 27;              // chunk of r2 and of mu*mag
    localparam int SChunkW  = 28;              // chunk of the root
    localparam int PdW      = ChunkW + SChunkW;
    localparam int RowW     = PdW + SChunkW;
    localparam int MmW      = 80;              // mu * mag
    localparam int NkW      = 108;             // mu * mag * 5^12
    localparam int NumShift = 28;              // 10^12 * 2^16 = 5^12 * 2^28
    localparam int NumW     = NkW + NumShift;  // dividend
    localparam int DenW     = 136;             // r2 * root
    localparam int QW       = AccW;            // quotient bits kept
    localparam int Latency  = 113;             // accept edge to strobe

    localparam logic [MuW-1:0]     MuReset   = 40'd132758100000;
    localparam logic [SChunkW-1:0] Pow5Of12  = 28'd244140625;
    localparam logic [AccW-1:0]    AccMax    = 48'h7FFF_FFFF_FFFF;
    localparam logic [AccW-1:0]    AccMinMag = 48'h8000_0000_0000;

    // Per-item data that rides along the pipeline; lane 0 is x, lane 1 is y.
    typedef struct packed {
        logic                  vld;
        logic                  origin;
        logic [1:0]            neg;
        logic [1:0][MagW-1:0]  mag;
        logic [1:0][VelW-1:0]  vel;
    } t_side;

endpackage

FILE: hdl/gdu_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root of r2 * 2^32, one root bit
// per stage. Depends on gdu_pkg.
`timescale 1ns / 1ps

module gdu_sqrt_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gdu_pkg::t_side              i_side,
    input  logic [gdu_pkg::R2W-1:0]     i_r2,
    output gdu_pkg::t_side              o_side,
    output logic [gdu_pkg::R2W-1:0]     o_r2,
    output logic [gdu_pkg::SW-1:0]      o_root
);

    gdu_pkg::t_side                  r_side [0:gdu_pkg::SqrSteps-1];
    logic [gdu_pkg::R2W-1:0]         r_r2   [0:gdu_pkg::SqrSteps-1];
    logic [gdu_pkg::SqrRemW-1:0]     r_rem  [0:gdu_pkg::SqrSteps-1];
    logic [gdu_pkg::SW-1:0]          r_root [0:gdu_pkg::SqrSteps-1];

    for (genvar k = 0; k < gdu_pkg::SqrSteps; k++) begin : g_step
        gdu_pkg::t_side                              side_in;
        logic [gdu_pkg::R2W-1:0]                     r2_in;
        logic [gdu_pkg::SqrRemW-1:0]                 rem_in;
        logic [gdu_pkg::SW-1:0]                      root_in;
        logic [gdu_pkg::R2W+gdu_pkg::RadPad-1:0]     rad;
        logic [gdu_pkg::SqrRemW-1:0]                 rem_sh;
        logic [gdu_pkg::SqrRemW-1:0]                 trial;

        if (k == 0) begin : g_first
            assign side_in = i_side;
            assign r2_in   = i_r2;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign side_in = r_side[k-1];
            assign r2_in   = r_r2[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign rad    = {r2_in, {gdu_pkg::RadPad{1'b0}}};
        assign rem_sh = {rem_in[gdu_pkg::SqrRemW-3:0],
                         rad[2*(gdu_pkg::SqrSteps-1-k) +: 2]};
        assign trial  = {{(gdu_pkg::SqrRemW-gdu_pkg::SW-2){1'b0}}, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= side_in;
            end
            r_r2[k]   <= r2_in;
            if (rem_sh >= trial) begin
                r_rem[k]  <= rem_sh - trial;
                r_root[k] <= {root_in[gdu_pkg::SW-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh;
                r_root[k] <= {root_in[gdu_pkg::SW-2:0], 1'b0};
            end
        end
    end

    assign o_side = r_side[gdu_pkg::SqrSteps-1];
    assign o_r2   = r_r2[gdu_pkg::SqrSteps-1];
    assign o_root = r_root[gdu_pkg::SqrSteps-1];

endmodule

FILE: hdl/gdu_div_pipe.sv
// Pipelined restoring division for both acceleration lanes with a shared
// divisor, followed by saturation, sign and the output register. Depends on gdu_pkg.
`timescale 1ns / 1ps

module gdu_div_pipe (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gdu_pkg::t_side                         i_side,
    input  logic [gdu_pkg::DenW-1:0]               i_den,
    input  logic [1:0][gdu_pkg::NumW-1:0]          i_num,
    output logic                                   o_valid,
    output logic [1:0][gdu_pkg::VelW-1:0]          o_vel,
    output logic [1:0][gdu_pkg::AccW-1:0]          o_accel,
    output logic                                   o_sat,
    output logic                                   o_origin
);

    gdu_pkg::t_side               r_side [0:gdu_pkg::QW];
    logic [gdu_pkg::DenW-1:0]     r_den  [0:gdu_pkg::QW];
    logic [gdu_pkg::DenW-1:0]     r_rem  [0:gdu_pkg::QW][0:1];
    logic [gdu_pkg::QW-1:0]       r_lo   [0:gdu_pkg::QW][0:1];
    logic [gdu_pkg::QW-1:0]       r_q    [0:gdu_pkg::QW][0:1];
    logic                         r_ovf  [0:gdu_pkg::QW][0:1];

    // The quotient overflows 48 bits exactly when the dividend's upper part
    // already reaches the divisor.
    for (genvar l = 0; l < 2; l++) begin : g_head
        logic [gdu_pkg::NumW-gdu_pkg::QW-1:0] hi;
        logic                                 ovf;
        assign hi  = i_num[l][gdu_pkg::NumW-1:gdu_pkg::QW];
        assign ovf = gdu_pkg::DenW'(hi) >= i_den;
        always_ff @(posedge i_clk) begin
            r_ovf[0][l] <= ovf;
            r_rem[0][l] <= ovf ? '0 : gdu_pkg::DenW'(hi);
            r_lo[0][l]  <= i_num[l][gdu_pkg::QW-1:0];
            r_q[0][l]   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else begin
            r_side[0] <= i_side;
        end
        r_den[0]  <= i_den;
    end

    for (genvar k = 1; k <= gdu_pkg::QW; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= r_side[k-1];
            end
            r_den[k]  <= r_den[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [gdu_pkg::DenW:0] rem_sh;
            logic [gdu_pkg::DenW:0] den_ext;
            logic                   ge;
            assign rem_sh  = {r_rem[k-1][l], r_lo[k-1][l][gdu_pkg::QW-1]};
            assign den_ext = {1'b0, r_den[k-1]};
            assign ge      = rem_sh >= den_ext;
            always_ff @(posedge i_clk) begin
                r_ovf[k][l] <= r_ovf[k-1][l];
                r_lo[k][l]  <= {r_lo[k-1][l][gdu_pkg::QW-2:0], 1'b0};
                r_q[k][l]   <= {r_q[k-1][l][gdu_pkg::QW-2:0], ge};
                r_rem[k][l] <= ge ? gdu_pkg::DenW'(rem_sh - den_ext)
                                  : rem_sh[gdu_pkg::DenW-1:0];
            end
        end
    end

    // Saturation and sign: the acceleration points toward the origin.
    logic [1:0]                    n_neg_res;
    logic [1:0]                    n_zero;
    logic [1:0]                    n_clip;
    logic [1:0][gdu_pkg::AccW-1:0] n_lim;
    logic [1:0][gdu_pkg::AccW-1:0] n_mag;
    logic [1:0][gdu_pkg::AccW-1:0] n_acc;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_neg_res[l] = ~r_side[gdu_pkg::QW].neg[l];
            n_lim[l]     = n_neg_res[l] ? gdu_pkg::AccMinMag : gdu_pkg::AccMax;
            n_zero[l]    = (r_side[gdu_pkg::QW].mag[l] == '0);
            n_clip[l]    = !n_zero[l]
                         && (r_ovf[gdu_pkg::QW][l] || (r_q[gdu_pkg::QW][l] > n_lim[l]));
            n_mag[l]     = n_clip[l] ? n_lim[l] : r_q[gdu_pkg::QW][l];
            n_acc[l]     = n_zero[l] ? '0
                         : (n_neg_res[l] ? (~n_mag[l] + 1'b1) : n_mag[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_vel    <= r_side[gdu_pkg::QW].vel;
        o_accel  <= n_acc;
        o_sat    <= |n_clip;
        o_origin <= r_side[gdu_pkg::QW].origin;
        o_valid  <= i_rst_n && r_side[gdu_pkg::QW].vld;
    end

endmodule

FILE: hdl/two_body_gravity_derivative_unit.sv
// Top level of the two-body gravity derivative unit: input stage, squaring,
// the wide products and the register. Depends on gdu_pkg, gdu_sqrt_pipe, gdu_div_pipe.
`timescale 1ns / 1ps

// Usage
// A request carries one planar orbit state (i_pos_x, i_pos_y in km, i_vel_x,
// i_vel_y in mm/s). It is accepted at a rising edge where start is high and
// busy is low. busy is always low: the unit is a fully pipelined datapath and
// takes a new request in every cycle, so states from an integrator can be
// streamed back to back.
// Each result shows up with o_valid high for one cycle. o_rate_x/o_rate_y
// repeat the velocities, and o_accel_x/o_accel_y give the acceleration in
// nm/s^2, saturated to 48 bits with o_saturated set when clamped. A state at
// the origin gives zero accelerations and sets o_at_origin. Results leave in
// request order.
// The latency is set by the square root (56 stages, one root bit each) and
// the divider (an overflow check stage, 48 stages of one quotient bit each and
// the output register) plus the input, two squaring and four multiplier stages.
// The receiver cannot stall the unit.
// The gravitational parameter is written through i_cfg_we/i_cfg_wdata while
// no request is in flight. Synchronous reset clears the sideband registers
// that carry the valid bits and loads the default parameter; the wide data
// registers are not reset.

module two_body_gravity_derivative_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gdu_pkg::PosW-1:0]     i_pos_x,
    input  logic signed [gdu_pkg::PosW-1:0]     i_pos_y,
    input  logic signed [gdu_pkg::VelW-1:0]     i_vel_x,
    input  logic signed [gdu_pkg::VelW-1:0]     i_vel_y,
    input  logic                                i_cfg_we,
    input  logic [gdu_pkg::MuW-1:0]             i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [gdu_pkg::VelW-1:0]     o_rate_x,
    output logic signed [gdu_pkg::VelW-1:0]     o_rate_y,
    output logic signed [gdu_pkg::AccW-1:0]     o_accel_x,
    output logic signed [gdu_pkg::AccW-1:0]     o_accel_y,
    output logic                                o_saturated,
    output logic                                o_at_origin
);

    // The pipeline never holds off a request.
    assign busy = 1'b0;

    // Gravitational parameter register.
    logic [gdu_pkg::MuW-1:0] r_grav_param;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_param <= gdu_pkg::MuReset;
        end else if (i_cfg_we) begin
            r_grav_param <= i_cfg_wdata;
        end
    end

    // Input stage: magnitudes and signs of the coordinates.
    gdu_pkg::t_side n_s0;
    gdu_pkg::t_side r_s0;

    always_comb begin
        n_s0        = '0;
        n_s0.vld    = start & ~busy;
        n_s0.origin = (i_pos_x == '0) && (i_pos_y == '0);
        n_s0.neg[0] = i_pos_x[gdu_pkg::PosW-1];
        n_s0.neg[1] = i_pos_y[gdu_pkg::PosW-1];
        n_s0.mag[0] = i_pos_x[gdu_pkg::PosW-1] ? (~unsigned'(i_pos_x) + 1'b1)
                                               : unsigned'(i_pos_x);
        n_s0.mag[1] = i_pos_y[gdu_pkg::PosW-1] ? (~unsigned'(i_pos_y) + 1'b1)
                                               : unsigned'(i_pos_y);
        n_s0.vel[0] = i_vel_x;
        n_s0.vel[1] = i_vel_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else begin
            r_s0 <= n_s0;
        end
    end

    // Squaring: each 40-bit magnitude is split in two 20-bit halves, giving
    // the low square, the cross product and the high square.
    gdu_pkg::t_side                         r_s1;
    logic [1:0][2:0][gdu_pkg::SqW-1:0]      n_sq;
    logic [1:0][2:0][gdu_pkg::SqW-1:0]      r_sq;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_sq[l][0] = gdu_pkg::SqW'(r_s0.mag[l][gdu_pkg::HalfW-1:0])
                       * gdu_pkg::SqW'(r_s0.mag[l][gdu_pkg::HalfW-1:0]);
            n_sq[l][1] = gdu_pkg::SqW'(r_s0.mag[l][gdu_pkg::HalfW-1:0])
                       * gdu_pkg::SqW'(r_s0.mag[l][gdu_pkg::MagW-1:gdu_pkg::HalfW]);
            n_sq[l][2] = gdu_pkg::SqW'(r_s0.mag[l][gdu_pkg::MagW-1:gdu_pkg::HalfW])
                       * gdu_pkg::SqW'(r_s0.mag[l][gdu_pkg::MagW-1:gdu_pkg::HalfW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= r_s0;
        end
        r_sq <= n_sq;
    end

    // Sum of squares; the cross product counts twice, hence the extra shift.
    gdu_pkg::t_side            r_s2;
    logic [gdu_pkg::R2W-1:0]   n_r2;
    logic [gdu_pkg::R2W-1:0]   r_r2;

    always_comb begin
        n_r2 = '0;
        for (int l = 0; l < 2; l++) begin
            n_r2 = n_r2 + gdu_pkg::R2W'(r_sq[l][0])
                 + (gdu_pkg::R2W'(r_sq[l][1]) << (gdu_pkg::HalfW + 1))
                 + (gdu_pkg::R2W'(r_sq[l][2]) << (2 * gdu_pkg::HalfW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= r_s1;
        end
        r_r2 <= n_r2;
    end

    // Root of the distance in Q.16.
    gdu_pkg::t_side              sq_side;
    logic [gdu_pkg::R2W-1:0]     sq_r2;
    logic [gdu_pkg::SW-1:0]      sq_root;

    gdu_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_s2),
        .i_r2    (r_r2),
        .o_side  (sq_side),
        .o_r2    (sq_r2),
        .o_root  (sq_root)
    );

    // First product stage: partial products of r2 * root (27 x 28 bit
    // pieces) and of mu * |c| (20 x 20 bit pieces) for both lanes.
    gdu_pkg::t_side                             r_p1_side;
    logic [2:0][gdu_pkg::ChunkW-1:0]            c_r2;
    logic [1:0][gdu_pkg::SChunkW-1:0]           c_root;
    logic [2:0][1:0][gdu_pkg::PdW-1:0]          n_pd;
    logic [2:0][1:0][gdu_pkg::PdW-1:0]          r_pd;
    logic [1:0][1:0][1:0][gdu_pkg::SqW-1:0]     n_pm;
    logic [1:0][1:0][1:0][gdu_pkg::SqW-1:0]     r_pm;

    assign c_r2[0]   = sq_r2[gdu_pkg::ChunkW-1:0];
    assign c_r2[1]   = sq_r2[2*gdu_pkg::ChunkW-1:gdu_pkg::ChunkW];
    assign c_r2[2]   = gdu_pkg::ChunkW'(sq_r2[gdu_pkg::R2W-1:2*gdu_pkg::ChunkW]);
    assign c_root[0] = sq_root[gdu_pkg::SChunkW-1:0];
    assign c_root[1] = sq_root[gdu_pkg::SW-1:gdu_pkg::SChunkW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) begin
                n_pd[i][j] = gdu_pkg::PdW'(c_r2[i]) * gdu_pkg::PdW'(c_root[j]);
            end
        end
        for (int l = 0; l < 2; l++) begin
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    n_pm[l][i][j] =
                        gdu_pkg::SqW'(r_grav_param[i*gdu_pkg::HalfW +: gdu_pkg::HalfW])
                      * gdu_pkg::SqW'(sq_side.mag[l][j*gdu_pkg::HalfW +: gdu_pkg::HalfW]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side <= '0;
        end else begin
            r_p1_side <= sq_side;
        end
        r_pd      <= n_pd;
        r_pm      <= n_pm;
    end

    // Second product stage: rows of the divisor and mu * |c|.
    gdu_pkg::t_side                     r_p2_side;
    logic [2:0][gdu_pkg::RowW-1:0]      n_row;
    logic [2:0][gdu_pkg::RowW-1:0]      r_row;
    logic [1:0][gdu_pkg::MmW-1:0]       n_mm;
    logic [1:0][gdu_pkg::MmW-1:0]       r_mm;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_row[i] = gdu_pkg::RowW'(r_pd[i][0])
                     + (gdu_pkg::RowW'(r_pd[i][1]) << gdu_pkg::SChunkW);
        end
        for (int l = 0; l < 2; l++) begin
            n_mm[l] = gdu_pkg::MmW'(r_pm[l][0][0])
                    + (gdu_pkg::MmW'(r_pm[l][0][1]) << gdu_pkg::HalfW)
                    + (gdu_pkg::MmW'(r_pm[l][1][0]) << gdu_pkg::HalfW)
                    + (gdu_pkg::MmW'(r_pm[l][1][1]) << (2 * gdu_pkg::HalfW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_side <= '0;
        end else begin
            r_p2_side <= r_p1_side;
        end
        r_row     <= n_row;
        r_mm      <= n_mm;
    end

    // Third product stage: divisor sum and the pieces of mu * |c| * 5^12.
    gdu_pkg::t_side                        r_p3_side;
    logic [gdu_pkg::DenW-1:0]              n_den3;
    logic [gdu_pkg::DenW-1:0]              r_den3;
    logic [1:0][2:0][gdu_pkg::PdW-1:0]     n_pk;
    logic [1:0][2:0][gdu_pkg::PdW-1:0]     r_pk;

    always_comb begin
        n_den3 = gdu_pkg::DenW'(r_row[0])
               + (gdu_pkg::DenW'(r_row[1]) << gdu_pkg::ChunkW)
               + (gdu_pkg::DenW'(r_row[2]) << (2 * gdu_pkg::ChunkW));
        for (int l = 0; l < 2; l++) begin
            n_pk[l][0] = gdu_pkg::PdW'(r_mm[l][gdu_pkg::ChunkW-1:0])
                       * gdu_pkg::PdW'(gdu_pkg::Pow5Of12);
            n_pk[l][1] = gdu_pkg::PdW'(r_mm[l][2*gdu_pkg::ChunkW-1:gdu_pkg::ChunkW])
                       * gdu_pkg::PdW'(gdu_pkg::Pow5Of12);
            n_pk[l][2] = gdu_pkg::PdW'(r_mm[l][gdu_pkg::MmW-1:2*gdu_pkg::ChunkW])
                       * gdu_pkg::PdW'(gdu_pkg::Pow5Of12);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_side <= '0;
        end else begin
            r_p3_side <= r_p2_side;
        end
        r_den3    <= n_den3;
        r_pk      <= n_pk;
    end

    // Fourth product stage: dividend mu * |c| * 10^12 * 2^16.
    gdu_pkg::t_side                     r_p4_side;
    logic [gdu_pkg::DenW-1:0]           r_den4;
    logic [1:0][gdu_pkg::NumW-1:0]      n_num;
    logic [1:0][gdu_pkg::NumW-1:0]      r_num;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_num[l] = {gdu_pkg::NkW'(gdu_pkg::NkW'(r_pk[l][0])
                          + (gdu_pkg::NkW'(r_pk[l][1]) << gdu_pkg::ChunkW)
                          + (gdu_pkg::NkW'(r_pk[l][2]) << (2 * gdu_pkg::ChunkW))),
                        {gdu_pkg::NumShift{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_side <= '0;
        end else begin
            r_p4_side <= r_p3_side;
        end
        r_den4    <= r_den3;
        r_num     <= n_num;
    end

    // Division, saturation and the output register.
    logic [1:0][gdu_pkg::VelW-1:0] out_vel;
    logic [1:0][gdu_pkg::AccW-1:0] out_acc;

    gdu_div_pipe u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_side   (r_p4_side),
        .i_den    (r_den4),
        .i_num    (r_num),
        .o_valid  (o_valid),
        .o_vel    (out_vel),
        .o_accel  (out_acc),
        .o_sat    (o_saturated),
        .o_origin (o_at_origin)
    );

    assign o_rate_x  = out_vel[0];
    assign o_rate_y  = out_vel[1];
    assign o_accel_x = out_acc[0];
    assign o_accel_y = out_acc[1];

    // Every accepted request produces its result strobe on o_valid.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(gdu_pkg::Latency) o_valid)
        else $error("result strobe missing after pipeline latency");

    // A state at the origin never reports a clamp and has zero acceleration.
    a_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_origin) |->
            (!o_saturated && (o_accel_x == '0) && (o_accel_y == '0)))
        else $error("origin result with nonzero acceleration or clamp");

    // A clamp leaves at least one component on a limit of its range.
    a_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            ((o_accel_x == gdu_pkg::AccMax) || (o_accel_x == gdu_pkg::AccMinMag)
          || (o_accel_y == gdu_pkg::AccMax) || (o_accel_y == gdu_pkg::AccMinMag)))
        else $error("saturation flag without a clamped acceleration");

    // No strobe comes out of an empty pipeline right after reset.
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe directly after reset");

endmodule

FILE: dv/tb_two_body_gravity_derivative_unit.sv
// Self-checking testbench for the two-body gravity derivative unit: directed table,
// randomized orbit states, config sweeps and idle phases. Depends on gdu_pkg and the RTL.
`timescale 1ns / 1ps

module tb_two_body_gravity_derivative_unit;

    localparam int PosW    = gdu_pkg::PosW;
    localparam int VelW    = gdu_pkg::VelW;
    localparam int AccW    = gdu_pkg::AccW;
    localparam int MuW     = gdu_pkg::MuW;
    localparam int SW      = gdu_pkg::SW;
    localparam int RadPad  = gdu_pkg::RadPad;
    localparam int Latency = gdu_pkg::Latency;
    localparam logic [MuW-1:0]  MuReset   = gdu_pkg::MuReset;
    localparam logic [AccW-1:0] AccMax    = gdu_pkg::AccMax;
    localparam logic [AccW-1:0] AccMinMag = gdu_pkg::AccMinMag;

    localparam int CycleLimit = 200000;
    localparam int MaxReports = 10;

    // Wide enough for mu * |c| * 10^12 * 2^16 (< 2^135) and r2 * root (< 2^136).
    typedef logic [191:0] t_wide;

    typedef struct packed {
        logic [VelW-1:0] rate_x;
        logic [VelW-1:0] rate_y;
        logic [AccW-1:0] accel_x;
        logic [AccW-1:0] accel_y;
        logic            saturated;
        logic            at_origin;
    } t_deriv;

    // One row of the directed part. When known is set, the expected
    // derivative is typed in the row instead of coming from the predictor.
    typedef struct packed {
        logic [MuW-1:0]  mu;
        logic [PosW-1:0] px;
        logic [PosW-1:0] py;
        logic [VelW-1:0] vx;
        logic [VelW-1:0] vy;
        logic            known;
        logic [AccW-1:0] ax;
        logic [AccW-1:0] ay;
        logic            sat;
        logic            org;
    } t_row;

    localparam logic [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
    localparam logic [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};
    localparam logic [PosW-1:0] PosOne = 40'd1;
    localparam logic [PosW-1:0] PosM1  = {PosW{1'b1}};
    localparam logic [VelW-1:0] VelMax = 32'h7FFF_FFFF;
    localparam logic [VelW-1:0] VelMin = 32'h8000_0000;
    localparam logic [MuW-1:0]  MuMax  = {MuW{1'b1}};
    localparam logic [AccW-1:0] AccNeg = AccMinMag;   // -2^47 as a pattern

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [PosW-1:0] i_pos_x = '0;
    logic signed [PosW-1:0] i_pos_y = '0;
    logic signed [VelW-1:0] i_vel_x = '0;
    logic signed [VelW-1:0] i_vel_y = '0;
    logic                   i_cfg_we = 1'b0;
    logic [MuW-1:0]         i_cfg_wdata = '0;
    logic                   o_valid;
    logic signed [VelW-1:0] o_rate_x;
    logic signed [VelW-1:0] o_rate_y;
    logic signed [AccW-1:0] o_accel_x;
    logic signed [AccW-1:0] o_accel_y;
    logic                   o_saturated;
    logic                   o_at_origin;

    two_body_gravity_derivative_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_rate_x    (o_rate_x),
        .o_rate_y    (o_rate_y),
        .o_accel_x   (o_accel_x),
        .o_accel_y   (o_accel_y),
        .o_saturated (o_saturated),
        .o_at_origin (o_at_origin)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: the gravitational parameter as the block holds it.
    logic [MuW-1:0] mu_model = MuReset;
    t_deriv         pending_derivs[$];
    // Typed expectations are queued here and consumed by the monitor at
    // acceptance in place of a prediction.
    t_deriv         typed_derivs[$];
    logic           use_typed = 1'b0;

    int cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int idle_pct = 0;
    int sat_seen = 0;
    int origin_seen = 0;

    function automatic t_wide root_floor(t_wide t);
        t_wide s;
        t_wide c;
        s = '0;
        for (int b = SW; b >= 0; b--) begin
            c = s | (t_wide'(1) << b);
            if (c * c <= t) s = c;
        end
        return s;
    endfunction

    // Signed acceleration of one lane; the sign is applied here, and sat reports a clamp.
    function automatic logic [AccW-1:0] lane_accel(logic [MuW-1:0] mu, logic [PosW-1:0] mag,
                                                   logic neg_c, t_wide den, output logic sat);
        t_wide num;
        t_wide q;
        t_wide lim;
        sat = 1'b0;
        if (mag == '0) return '0;
        num = t_wide'(mu) * t_wide'(mag) * t_wide'(64'd1000000000000) * t_wide'(65536);
        q = num / den;
        // The acceleration points toward the origin, against the coordinate sign.
        lim = neg_c ? t_wide'(AccMax) : t_wide'(AccMinMag);
        if (q > lim) begin
            sat = 1'b1;
            q = lim;
        end
        return neg_c ? q[AccW-1:0] : AccW'(-q[AccW-1:0]);
    endfunction

    function automatic t_deriv grav_deriv_predict(logic [PosW-1:0] x, logic [PosW-1:0] y,
                                                  logic [VelW-1:0] vx, logic [VelW-1:0] vy,
                                                  logic [MuW-1:0] mu);
        t_deriv d;
        logic [PosW-1:0] mx;
        logic [PosW-1:0] my;
        t_wide r2;
        t_wide s;
        logic sx;
        logic sy;
        mx = x[PosW-1] ? PosW'(-x) : x;
        my = y[PosW-1] ? PosW'(-y) : y;
        d = '0;
        d.rate_x = vx;
        d.rate_y = vy;
        if (mx == '0 && my == '0) begin
            d.at_origin = 1'b1;
        end else begin
            r2 = t_wide'(mx) * t_wide'(mx) + t_wide'(my) * t_wide'(my);
            s = root_floor(r2 << RadPad);
            d.accel_x = lane_accel(mu, mx, x[PosW-1], r2 * s, sx);
            d.accel_y = lane_accel(mu, my, y[PosW-1], r2 * s, sy);
            d.saturated = sx | sy;
        end
        return d;
    endfunction

    // Monitor: the result from an earlier request is checked first, then a
    // request accepted at this edge is predicted and queued.
    always @(posedge i_clk) begin
        t_deriv got;
        t_deriv want;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_derivs.size());
            $display("FAIL two_body_gravity_derivative_unit");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid) begin
                got = '{o_rate_x, o_rate_y, o_accel_x, o_accel_y, o_saturated, o_at_origin};
                results_seen++;
                if (o_saturated) sat_seen++;
                if (o_at_origin) origin_seen++;
                if (pending_derivs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("result with nothing expected: %p", got);
                end else begin
                    want = pending_derivs.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MaxReports)
                            $display("mismatch at cycle %0d\n  expected %p\n  actual   %p",
                                     cycles, want, got);
                    end
                end
            end
            if (i_cfg_we) mu_model <= i_cfg_wdata;
            if (start && !busy) begin
                if (use_typed && typed_derivs.size() > 0)
                    pending_derivs.push_back(typed_derivs.pop_front());
                else
                    pending_derivs.push_back(grav_deriv_predict(i_pos_x, i_pos_y,
                                                                i_vel_x, i_vel_y, mu_model));
            end
        end
    end

    // Presents one request, with random idle cycles ahead of it, and returns
    // at the edge where it is accepted.
    task automatic send_request(logic [PosW-1:0] x, logic [PosW-1:0] y,
                                logic [VelW-1:0] vx, logic [VelW-1:0] vy);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_vel_x <= vx;
        i_vel_y <= vy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_sent++;
    endtask

    // The register may only change with nothing in flight, so drain first.
    task automatic write_grav_param(logic [MuW-1:0] mu);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_derivs.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mu;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [PosW-1:0] rand_pos();
        logic [PosW-1:0] p;
        p = PosW'({$urandom, $urandom});
        case ($urandom_range(4))
            0: return p;                                              // full range
            1: return PosW'($signed(p[7:0]));                          // near the origin
            2: return PosW'($signed(p[31:0])) >>> $urandom_range(20);  // planetary scale
            3: return $urandom_range(1) ? PosW'(p[29:0]) : PosW'(-p[29:0]);
            default: return $urandom_range(1) ? '0 : p;                // one axis zero
        endcase
    endfunction

    t_row directed[] = '{
        // State at the origin: zero accelerations and the origin flag.
        '{MuReset, '0, '0, VelMax, VelMin, 1'b1, '0, '0, 1'b0, 1'b1},
        // One km out on each axis: far beyond range, so saturated toward origin.
        '{MuReset, PosOne, '0, 32'd1, 32'd2, 1'b1, AccNeg, '0, 1'b1, 1'b0},
        '{MuReset, PosM1, '0, '0, '0, 1'b1, AccMax, '0, 1'b1, 1'b0},
        '{MuReset, '0, PosOne, VelMin, VelMax, 1'b1, '0, AccNeg, 1'b1, 1'b0},
        '{MuReset, '0, PosM1, 32'hFFFF_FFFF, '0, 1'b1, '0, AccMax, 1'b1, 1'b0},
        // Extremes of the position range and ordinary orbit distances.
        '{MuReset, PosMax, '0, VelMax, VelMax, 1'b0, '0, '0, 1'b0, 1'b0},
        '{MuReset, PosMin, PosMin, VelMin, VelMin, 1'b0, '0, '0, 1'b0, 1'b0},
        '{MuReset, PosMax, PosMax, 32'd29780000, '0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{MuReset, 40'd149600000, '0, '0, 32'd29780000, 1'b0, '0, '0, 1'b0, 1'b0},
        '{MuReset, 40'd100000000, PosW'(-40'sd100000000), 32'd5, 32'd7,
          1'b0, '0, '0, 1'b0, 1'b0},
        '{MuReset, 40'd1000, 40'd1000, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0},
        // Zero parameter: no pull and no flag, even right next to the origin.
        '{'0, PosOne, PosOne, 32'd3, 32'd4, 1'b1, '0, '0, 1'b0, 1'b0},
        '{'0, PosMin, PosMax, VelMax, VelMin, 1'b1, '0, '0, 1'b0, 1'b0},
        // Largest parameter.
        '{MuMax, PosMax, PosMin, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{MuMax, 40'd149600000, 40'd3, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{MuMax, '0, '0, 32'd9, 32'd9, 1'b1, '0, '0, 1'b0, 1'b1},
        // Smallest nonzero parameter.
        '{40'd1, 40'd1000000, 40'd1000000, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0},
        '{40'd1, 40'd7, PosW'(-40'sd3), '0, '0, 1'b0, '0, '0, 1'b0, 1'b0}
    };

    initial begin
        logic [MuW-1:0] mu_now;
        logic [MuW-1:0] mu_plan[5];
        int idle_plan[4];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the register is rewritten whenever a row asks for
        // a new parameter.
        mu_now = MuReset;
        use_typed = 1'b1;
        foreach (directed[i]) begin
            if (directed[i].mu != mu_now) begin
                write_grav_param(directed[i].mu);
                mu_now = directed[i].mu;
            end
            if (directed[i].known)
                typed_derivs.push_back('{directed[i].vx, directed[i].vy, directed[i].ax,
                                         directed[i].ay, directed[i].sat, directed[i].org});
            else
                typed_derivs.push_back(grav_deriv_predict(directed[i].px, directed[i].py,
                                                          directed[i].vx, directed[i].vy,
                                                          directed[i].mu));
            send_request(directed[i].px, directed[i].py, directed[i].vx, directed[i].vy);
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_derivs.size() != 0) @(posedge i_clk);
        use_typed = 1'b0;

        // Random part: each parameter setting runs through the idle phases.
        // The drain before every register write also makes the sender wait
        // for all outstanding results at least once.
        mu_plan = '{MuReset, MuMax, 40'd1, MuW'({$urandom, $urandom}), '0};
        idle_plan = '{0, 61, 0, 22};
        foreach (mu_plan[m]) begin
            write_grav_param(mu_plan[m]);
            foreach (idle_plan[p]) begin
                idle_pct = idle_plan[p];
                repeat (28) send_request(rand_pos(), rand_pos(), $urandom, $urandom);
            end
        end
        idle_pct = 0;
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_derivs.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (pending_derivs.size() != 0) mismatches++;

        $display("%0d requests, %0d derivatives checked (%0d saturated, %0d at origin),",
                 requests_sent, results_seen, sat_seen, origin_seen);
        $display("five parameter settings incl. 0 and full scale, idle phases 0/22/61 pct");
        if (mismatches == 0) begin
            $display("PASS two_body_gravity_derivative_unit");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL two_body_gravity_derivative_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/gdu_pkg.sv
hdl/gdu_sqrt_pipe.sv
hdl/gdu_div_pipe.sv
hdl/two_body_gravity_derivative_unit.sv
dv/tb_two_body_gravity_derivative_unit.sv
